@@ src/dce_pkg.sv @@
// Shared constants, types and elaboration-time helpers for the decline curve evaluator.
// Used by dce_mul and decline_curve_evaluator; depends on nothing else.
`default_nettype none

package dce_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_MODE    = 2'd0;
   localparam logic [1:0] CSR_PARAM_A = 2'd1;
   localparam logic [1:0] CSR_PARAM_B = 2'd2;
   localparam logic [1:0] CSR_PARAM_C = 2'd3;

   // curve kinds held in the mode register
   localparam logic [1:0] MODE_EXP   = 2'd0;
   localparam logic [1:0] MODE_POWER = 2'd1;
   localparam logic [1:0] MODE_HYPER = 2'd2;
   localparam logic [1:0] MODE_PIECE = 2'd3;

   // per-item evaluation path
   localparam logic [2:0] KIND_EXP  = 3'd0;  // exponential, E from a*x*log2(e)
   localparam logic [2:0] KIND_LOG  = 3'd1;  // power law, E = a*log2(1+x)
   localparam logic [2:0] KIND_LOG3 = 3'd2;  // piecewise first segment, E = b*log2(1+x)
   localparam logic [2:0] KIND_HYP  = 3'd3;  // hyperbolic, E = log2(1+t)/b
   localparam logic [2:0] KIND_ONE  = 3'd4;  // zero hyperbolic exponent, y = 1.0

   // exponent saturation value, 2^40 in Q.32 (any E >= 33 gives zero)
   localparam logic [40:0] E_CAP = 41'h100_0000_0000;
   // log2(e) in Q.40
   localparam logic [47:0] LOG2E_Q40 = 48'h0171_5476_52B8;

   // shared multiplier geometry
   localparam int MUL_AW = 64;
   localparam int MUL_BW = 48;
   localparam int MUL_PW = MUL_AW + MUL_BW;

   typedef struct packed {
      logic       last;
      logic [2:0] kind;
   } side_type;

   // digit-by-digit integer square root, evaluated at elaboration
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v    = v_in;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // factor 2^-(2^-(k+1)) in Q.32, built by repeated square roots
   function automatic logic [31:0] pow_entry(input int k);
      logic [63:0] t;
      t = isqrt64(64'h8000_0000_0000_0000);
      for (int j = 1; j <= k; j++) begin
         t = isqrt64({t[31:0], 32'h0});
      end
      return t[31:0];
   endfunction

endpackage

`default_nettype wire

@@ src/dce_mul.sv @@
// Two-stage 64x48 unsigned multiplier: 32x24 partial products, then their sum.
// Depends on dce_pkg for operand and product widths.
`default_nettype none

module dce_mul (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [dce_pkg::MUL_AW-1:0] op_a,
   input  wire logic [dce_pkg::MUL_BW-1:0] op_b,
   output logic      [dce_pkg::MUL_PW-1:0] prod
);

   logic [55:0] pp_ll_ff;
   logic [55:0] pp_lh_ff;
   logic [55:0] pp_hl_ff;
   logic [55:0] pp_hh_ff;
   logic [dce_pkg::MUL_PW-1:0] prod_ff;
   logic [dce_pkg::MUL_PW-1:0] prod_in;

   // first stage: four narrow partial products
   always_ff @(posedge clock) begin
      if (en) begin
         pp_ll_ff <= 56'(op_a[31:0])  * 56'(op_b[23:0]);
         pp_lh_ff <= 56'(op_a[31:0])  * 56'(op_b[47:24]);
         pp_hl_ff <= 56'(op_a[63:32]) * 56'(op_b[23:0]);
         pp_hh_ff <= 56'(op_a[63:32]) * 56'(op_b[47:24]);
      end
   end

   // second stage: align and add
   assign prod_in = dce_pkg::MUL_PW'(pp_ll_ff)
                  + (dce_pkg::MUL_PW'(pp_lh_ff) << 24)
                  + (dce_pkg::MUL_PW'(pp_hl_ff) << 32)
                  + (dce_pkg::MUL_PW'(pp_hh_ff) << 56);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

@@ src/decline_curve_evaluator.sv @@
// Decline curve evaluator top level: register file, full datapath pipeline, output buffer.
// Depends on dce_pkg and dce_mul.
`default_nettype none

// Streams one time point x (Q20.12) per item and returns y = 2^-E in Q1.31 for the
// curve kind in the mode register. One item is taken every cycle while the output
// buffer is not full. The datapath is a chain of fixed stages: three
// pipelined multipliers, a 32-step squaring log2, a 41-step restoring divider and a
// 32-step factor product for 2^-E. A two-entry output buffer lets the pipeline keep
// moving while a result waits; the pipeline halts only when both entries are full.
// Registers must be written with csr_we only while no item is in flight; not enforced.

module decline_curve_evaluator (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] time_point
   input  wire logic        req_tlast,   // last_in
   // result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [31:0] decline_value
   output logic             rsp_tlast,   // last_out
   // register writes
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);

   // ---------------------------------------------------------------- registers
   logic [1:0]  mode_ff;
   logic [47:0] a_ff;
   logic [47:0] b_ff;
   logic [47:0] c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= dce_pkg::MODE_EXP;
         a_ff    <= '0;
         b_ff    <= '0;
         c_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            dce_pkg::CSR_MODE:    mode_ff <= csr_wdata[1:0];
            dce_pkg::CSR_PARAM_A: a_ff    <= csr_wdata;
            dce_pkg::CSR_PARAM_B: b_ff    <= csr_wdata;
            dce_pkg::CSR_PARAM_C: c_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic b_zero;
   assign b_zero = (b_ff == '0);

   // global advance: the pipeline moves unless the output buffer is full
   logic       en;
   logic [1:0] ob_cnt_ff;
   assign en         = (ob_cnt_ff != 2'd2);
   assign req_tready = en;

   // ---------------------------------------------------------------- S1: capture
   logic        s1_v_ff;
   logic [31:0] s1_x_ff;
   logic        s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (en) s1_v_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff    <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // breakpoint test and first multiplier operands
   logic [43:0] s1_xs;
   logic        s1_first;
   logic [43:0] s1_diff;
   logic [2:0]  s1_kind;
   logic [63:0] m1_a;
   logic [47:0] m1_b;
   logic [111:0] p1;

   assign s1_xs    = {s1_x_ff, 12'h000};
   assign s1_first = ({4'h0, s1_xs} <= a_ff);
   assign s1_diff  = s1_xs - a_ff[43:0];

   always_comb begin
      case (mode_ff)
         dce_pkg::MODE_EXP:   s1_kind = dce_pkg::KIND_EXP;
         dce_pkg::MODE_POWER: s1_kind = dce_pkg::KIND_LOG;
         dce_pkg::MODE_HYPER: s1_kind = b_zero ? dce_pkg::KIND_ONE : dce_pkg::KIND_HYP;
         dce_pkg::MODE_PIECE: s1_kind = s1_first ? dce_pkg::KIND_LOG3 :
                                        (b_zero ? dce_pkg::KIND_ONE : dce_pkg::KIND_HYP);
         default:             s1_kind = dce_pkg::KIND_EXP;
      endcase
   end

   assign m1_a = (mode_ff == dce_pkg::MODE_PIECE) ? 64'(s1_diff) : 64'(s1_x_ff);
   assign m1_b = (mode_ff == dce_pkg::MODE_PIECE) ? b_ff : a_ff;

   dce_mul u_mul1 (.clock(clock), .en(en), .op_a(m1_a), .op_b(m1_b), .prod(p1));

   // ---------------------------------------------------------------- S2, S3: product u
   logic                s2_v_ff, s3_v_ff;
   logic [31:0]         s2_x_ff, s3_x_ff;
   dce_pkg::side_type   s2_side_ff, s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s2_x_ff    <= s1_x_ff;
         s2_side_ff <= '{last: s1_last_ff, kind: s1_kind};
         s3_x_ff    <= s2_x_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // ---------------------------------------------------------------- S4: bit length of u
   logic                s4_v_ff;
   logic [91:0]         s4_u_ff;
   logic                s4_over_ff;
   logic [31:0]         s4_x_ff;
   dce_pkg::side_type   s4_side_ff;
   logic [6:0]          s4_bl;
   logic [4:0]          s4_k;

   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (en) s4_v_ff <= s3_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s4_u_ff    <= p1[91:0];
         s4_over_ff <= |p1[111:42];
         s4_x_ff    <= s3_x_ff;
         s4_side_ff <= s3_side_ff;
      end
   end

   always_comb begin
      s4_bl = '0;
      for (int i = 0; i < 92; i++) begin
         if (s4_u_ff[i]) s4_bl = 7'(i + 1);
      end
   end
   assign s4_k = (s4_bl > 7'd63) ? 5'(s4_bl - 7'd63) : 5'd0;

   // ---------------------------------------------------------------- S5: shift u below 2^63
   logic                s5_v_ff;
   logic [91:0]         s5_u_ff;
   logic [4:0]          s5_k_ff;
   logic                s5_over_ff;
   logic [31:0]         s5_x_ff;
   dce_pkg::side_type   s5_side_ff;
   logic [91:0]         s5_ush;
   logic [6:0]          s5_ft;
   logic [63:0]         m2_a;
   logic [47:0]         m2_b;
   logic [111:0]        p2;

   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else if (en) s5_v_ff <= s4_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s5_u_ff    <= s4_u_ff;
         s5_k_ff    <= s4_k;
         s5_over_ff <= s4_over_ff;
         s5_x_ff    <= s4_x_ff;
         s5_side_ff <= s4_side_ff;
      end
   end

   assign s5_ush = s5_u_ff >> s5_k_ff;
   // fraction bits of t = u*r
   assign s5_ft  = ((mode_ff == dce_pkg::MODE_PIECE) ? 7'd104 : 7'd76) - {2'b00, s5_k_ff};
   assign m2_a   = (s5_side_ff.kind == dce_pkg::KIND_EXP) ? 64'(s5_u_ff[41:0])
                                                          : 64'(s5_ush[62:0]);
   assign m2_b   = (s5_side_ff.kind == dce_pkg::KIND_EXP) ? dce_pkg::LOG2E_Q40 :
                   ((mode_ff == dce_pkg::MODE_HYPER) ? b_ff : c_ff);

   dce_mul u_mul2 (.clock(clock), .en(en), .op_a(m2_a), .op_b(m2_b), .prod(p2));

   // ---------------------------------------------------------------- S6, S7: product t
   logic                s6_v_ff, s7_v_ff;
   logic [31:0]         s6_x_ff, s7_x_ff;
   logic [6:0]          s6_ft_ff, s7_ft_ff;
   logic                s6_over_ff, s7_over_ff;
   dce_pkg::side_type   s6_side_ff, s7_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
      end else if (en) begin
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s6_x_ff    <= s5_x_ff;
         s6_ft_ff   <= s5_ft;
         s6_over_ff <= s5_over_ff;
         s6_side_ff <= s5_side_ff;
         s7_x_ff    <= s6_x_ff;
         s7_ft_ff   <= s6_ft_ff;
         s7_over_ff <= s6_over_ff;
         s7_side_ff <= s6_side_ff;
      end
   end

   // ---------------------------------------------------------------- S8: log2 argument
   logic                s8_v_ff;
   logic [111:0]        s8_p_ff;
   logic [31:0]         s8_x_ff;
   logic [6:0]          s8_ft_ff;
   logic                s8_over_ff;
   dce_pkg::side_type   s8_side_ff;
   logic [111:0]        s8_val;
   logic [6:0]          s8_fl;
   logic [40:0]         s8_e;

   always_ff @(posedge clock) begin
      if (reset) s8_v_ff <= 1'b0;
      else if (en) s8_v_ff <= s7_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s8_p_ff    <= p2;
         s8_x_ff    <= s7_x_ff;
         s8_ft_ff   <= s7_ft_ff;
         s8_over_ff <= s7_over_ff;
         s8_side_ff <= s7_side_ff;
      end
   end

   // 1+t with ft fraction bits, or 1+x with 12
   assign s8_val = (s8_side_ff.kind == dce_pkg::KIND_HYP) ?
                   s8_p_ff + (112'd1 << s8_ft_ff) : 112'(s8_x_ff) + 112'd4096;
   assign s8_fl  = (s8_side_ff.kind == dce_pkg::KIND_HYP) ? s8_ft_ff : 7'd12;
   // exponential: a*x at or above 64 underflows
   assign s8_e   = s8_over_ff ? dce_pkg::E_CAP : 41'(s8_p_ff[82:44]);

   // ---------------------------------------------------------------- S9: leading one
   logic                s9_v_ff;
   logic [111:0]        s9_val_ff;
   logic [6:0]          s9_fl_ff;
   logic [40:0]         s9_e_ff;
   dce_pkg::side_type   s9_side_ff;
   logic [6:0]          s9_p;

   always_ff @(posedge clock) begin
      if (reset) s9_v_ff <= 1'b0;
      else if (en) s9_v_ff <= s8_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s9_val_ff  <= s8_val;
         s9_fl_ff   <= s8_fl;
         s9_e_ff    <= s8_e;
         s9_side_ff <= s8_side_ff;
      end
   end

   always_comb begin
      s9_p = '0;
      for (int i = 0; i < 112; i++) begin
         if (s9_val_ff[i]) s9_p = 7'(i);
      end
   end

   // ---------------------------------------------------------------- S10: normalize mantissa
   logic                s10_v_ff;
   logic [111:0]        s10_val_ff;
   logic [6:0]          s10_p_ff;
   logic [6:0]          s10_fl_ff;
   logic [40:0]         s10_e_ff;
   dce_pkg::side_type   s10_side_ff;
   logic [142:0]        s10_sh;

   always_ff @(posedge clock) begin
      if (reset) s10_v_ff <= 1'b0;
      else if (en) s10_v_ff <= s9_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s10_val_ff  <= s9_val_ff;
         s10_p_ff    <= s9_p;
         s10_fl_ff   <= s9_fl_ff;
         s10_e_ff    <= s9_e_ff;
         s10_side_ff <= s9_side_ff;
      end
   end

   // leading one lands on bit 31
   assign s10_sh = {s10_val_ff, 31'h0} >> s10_p_ff;

   // ---------------------------------------------------------------- log2 squaring chain
   logic              lg_v_ff    [0:32];
   logic [31:0]       lg_mm_ff   [0:31];
   logic [31:0]       lg_frac_ff [0:32];
   logic [6:0]        lg_ip_ff   [0:32];
   logic [40:0]       lg_e_ff    [0:32];
   dce_pkg::side_type lg_side_ff [0:32];

   always_ff @(posedge clock) begin
      if (reset) lg_v_ff[0] <= 1'b0;
      else if (en) lg_v_ff[0] <= s10_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         lg_mm_ff[0]   <= s10_sh[31:0];
         lg_frac_ff[0] <= '0;
         lg_ip_ff[0]   <= s10_p_ff - s10_fl_ff;
         lg_e_ff[0]    <= s10_e_ff;
         lg_side_ff[0] <= s10_side_ff;
      end
   end

   for (genvar gi = 0; gi < 32; gi++) begin : g_log
      logic [63:0] sq;
      logic [32:0] sq_hi;
      logic [31:0] frac_in;

      // one fraction bit per square
      assign sq    = 64'(lg_mm_ff[gi]) * 64'(lg_mm_ff[gi]);
      assign sq_hi = sq[63:31];
      always_comb begin
         frac_in         = lg_frac_ff[gi];
         frac_in[31-gi]  = sq_hi[32];
      end

      always_ff @(posedge clock) begin
         if (reset) lg_v_ff[gi+1] <= 1'b0;
         else if (en) lg_v_ff[gi+1] <= lg_v_ff[gi];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            lg_frac_ff[gi+1] <= frac_in;
            lg_ip_ff[gi+1]   <= lg_ip_ff[gi];
            lg_e_ff[gi+1]    <= lg_e_ff[gi];
            lg_side_ff[gi+1] <= lg_side_ff[gi];
         end
      end

      if (gi < 31) begin : g_mm
         always_ff @(posedge clock) begin
            if (en) begin
               lg_mm_ff[gi+1] <= sq_hi[32] ? sq_hi[32:1] : sq_hi[31:0];
            end
         end
      end
   end

   // ---------------------------------------------------------------- scale L, divide test
   logic [38:0]  lg_l;
   logic [63:0]  m3_a;
   logic [47:0]  m3_b;
   logic [111:0] p3;
   logic [88:0]  div_thr;
   logic         lg_dsat;

   assign lg_l    = {lg_ip_ff[32][6:0], lg_frac_ff[32]};
   assign m3_a    = 64'(lg_l);
   assign m3_b    = (lg_side_ff[32].kind == dce_pkg::KIND_LOG) ? a_ff : b_ff;
   // quotient (L << 40) / b exceeds 2^40
   assign div_thr = {1'b0, b_ff, 40'h0} + 89'(b_ff);
   assign lg_dsat = ({10'h000, lg_l, 40'h0} >= div_thr);

   dce_mul u_mul3 (.clock(clock), .en(en), .op_a(m3_a), .op_b(m3_b), .prod(p3));

   logic                s12_v_ff, s13_v_ff;
   logic [38:0]         s12_l_ff, s13_l_ff;
   logic                s12_sat_ff, s13_sat_ff;
   logic [40:0]         s12_e_ff, s13_e_ff;
   dce_pkg::side_type   s12_side_ff, s13_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s12_v_ff <= 1'b0;
         s13_v_ff <= 1'b0;
      end else if (en) begin
         s12_v_ff <= lg_v_ff[32];
         s13_v_ff <= s12_v_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s12_l_ff    <= lg_l;
         s12_sat_ff  <= lg_dsat;
         s12_e_ff    <= lg_e_ff[32];
         s12_side_ff <= lg_side_ff[32];
         s13_l_ff    <= s12_l_ff;
         s13_sat_ff  <= s12_sat_ff;
         s13_e_ff    <= s12_e_ff;
         s13_side_ff <= s12_side_ff;
      end
   end

   // exponent for the non-hyperbolic paths, saturated at 2^40
   logic [87:0] s13_v24;
   logic [71:0] s13_v40;
   logic [40:0] s13_epre;

   assign s13_v24 = p3[111:24];
   assign s13_v40 = p3[111:40];

   always_comb begin
      case (s13_side_ff.kind)
         dce_pkg::KIND_EXP:  s13_epre = s13_e_ff;
         dce_pkg::KIND_LOG:  s13_epre = (s13_v24 > 88'(dce_pkg::E_CAP)) ?
                                        dce_pkg::E_CAP : s13_v24[40:0];
         dce_pkg::KIND_LOG3: s13_epre = (s13_v40 > 72'(dce_pkg::E_CAP)) ?
                                        dce_pkg::E_CAP : s13_v40[40:0];
         default:            s13_epre = '0;
      endcase
   end

   // ---------------------------------------------------------------- restoring divider
   logic              dv_v_ff    [0:41];
   logic [48:0]       dv_cur_ff  [0:40];
   logic [40:0]       dv_q_ff    [0:41];
   logic              dv_sat_ff  [0:41];
   logic [40:0]       dv_e_ff    [0:41];
   dce_pkg::side_type dv_side_ff [0:41];

   always_ff @(posedge clock) begin
      if (reset) dv_v_ff[0] <= 1'b0;
      else if (en) dv_v_ff[0] <= s13_v_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         dv_cur_ff[0]  <= 49'(s13_l_ff);
         dv_q_ff[0]    <= '0;
         dv_sat_ff[0]  <= s13_sat_ff;
         dv_e_ff[0]    <= s13_epre;
         dv_side_ff[0] <= s13_side_ff;
      end
   end

   for (genvar gj = 0; gj < 41; gj++) begin : g_div
      logic        ge;
      logic [48:0] rem;

      assign ge  = (dv_cur_ff[gj] >= {1'b0, b_ff});
      assign rem = ge ? dv_cur_ff[gj] - {1'b0, b_ff} : dv_cur_ff[gj];

      always_ff @(posedge clock) begin
         if (reset) dv_v_ff[gj+1] <= 1'b0;
         else if (en) dv_v_ff[gj+1] <= dv_v_ff[gj];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_q_ff[gj+1]    <= {dv_q_ff[gj][39:0], ge};
            dv_sat_ff[gj+1]  <= dv_sat_ff[gj];
            dv_e_ff[gj+1]    <= dv_e_ff[gj];
            dv_side_ff[gj+1] <= dv_side_ff[gj];
         end
      end

      if (gj < 40) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               dv_cur_ff[gj+1] <= {rem[47:0], 1'b0};
            end
         end
      end
   end

   logic [40:0] dv_efin;
   assign dv_efin = (dv_side_ff[41].kind == dce_pkg::KIND_HYP) ?
                    (dv_sat_ff[41] ? dce_pkg::E_CAP : dv_q_ff[41]) : dv_e_ff[41];

   // ---------------------------------------------------------------- 2^-E factor chain
   logic              ex_v_ff    [0:32];
   logic [32:0]       ex_m_ff    [0:32];
   logic [31:0]       ex_f_ff    [0:31];
   logic [8:0]        ex_n_ff    [0:32];
   logic              ex_last_ff [0:32];

   always_ff @(posedge clock) begin
      if (reset) ex_v_ff[0] <= 1'b0;
      else if (en) ex_v_ff[0] <= dv_v_ff[41];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         ex_m_ff[0]    <= 33'h1_0000_0000;
         ex_f_ff[0]    <= dv_efin[31:0];
         ex_n_ff[0]    <= dv_efin[40:32];
         ex_last_ff[0] <= dv_side_ff[41].last;
      end
   end

   for (genvar gk = 0; gk < 32; gk++) begin : g_exp
      localparam logic [31:0] FACTOR = dce_pkg::pow_entry(gk);
      logic [64:0] prod;

      assign prod = 65'(ex_m_ff[gk]) * 65'(FACTOR);

      always_ff @(posedge clock) begin
         if (reset) ex_v_ff[gk+1] <= 1'b0;
         else if (en) ex_v_ff[gk+1] <= ex_v_ff[gk];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            ex_m_ff[gk+1]    <= ex_f_ff[gk][31-gk] ? prod[64:32] : ex_m_ff[gk];
            ex_n_ff[gk+1]    <= ex_n_ff[gk];
            ex_last_ff[gk+1] <= ex_last_ff[gk];
         end
      end

      if (gk < 31) begin : g_frac
         always_ff @(posedge clock) begin
            if (en) begin
               ex_f_ff[gk+1] <= ex_f_ff[gk];
            end
         end
      end
   end

   // final scale by 2^-n with round half up
   logic [33:0] ex_sum;
   logic [33:0] ex_sh;
   logic [31:0] ex_y;

   assign ex_sum = 34'(ex_m_ff[32]) + (34'd1 << ex_n_ff[32][5:0]);
   assign ex_sh  = ex_sum >> (ex_n_ff[32][5:0] + 6'd1);
   assign ex_y   = (ex_n_ff[32] >= 9'd33) ? 32'h0 : ex_sh[31:0];

   // ---------------------------------------------------------------- output buffer
   logic [31:0] ob0_y_ff, ob1_y_ff;
   logic        ob0_last_ff, ob1_last_ff;
   logic        ob_push, ob_pop;

   assign ob_push = en & ex_v_ff[32];
   assign ob_pop  = (ob_cnt_ff != 2'd0) & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_cnt_ff <= 2'd0;
      end else begin
         case (ob_cnt_ff)
            2'd0: begin
               if (ob_push) begin
                  ob0_y_ff    <= ex_y;
                  ob0_last_ff <= ex_last_ff[32];
                  ob_cnt_ff   <= 2'd1;
               end
            end
            2'd1: begin
               if (ob_push && ob_pop) begin
                  ob0_y_ff    <= ex_y;
                  ob0_last_ff <= ex_last_ff[32];
               end else if (ob_push) begin
                  ob1_y_ff    <= ex_y;
                  ob1_last_ff <= ex_last_ff[32];
                  ob_cnt_ff   <= 2'd2;
               end else if (ob_pop) begin
                  ob_cnt_ff   <= 2'd0;
               end
            end
            2'd2: begin
               if (ob_pop) begin
                  ob0_y_ff    <= ob1_y_ff;
                  ob0_last_ff <= ob1_last_ff;
                  ob_cnt_ff   <= 2'd1;
               end
            end
            default: ob_cnt_ff <= 2'd0;
         endcase
      end
   end

   assign rsp_tvalid = (ob_cnt_ff != 2'd0);
   assign rsp_tdata  = ob0_y_ff;
   assign rsp_tlast  = ob0_last_ff;

   // ---------------------------------------------------------------- assertions
   // results never exceed 1.0
   a_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata <= 32'h8000_0000))
      else $error("decline value above 1.0");

   // log2 mantissa enters the squaring chain normalized
   a_log_norm: assert property (@(posedge clock) disable iff (reset)
      (lg_v_ff[0] && (lg_side_ff[0].kind == dce_pkg::KIND_LOG ||
                      lg_side_ff[0].kind == dce_pkg::KIND_LOG3 ||
                      lg_side_ff[0].kind == dce_pkg::KIND_HYP)) |-> lg_mm_ff[0][31])
      else $error("log2 mantissa not normalized");

   // unsaturated quotient stays within the exponent range
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (dv_v_ff[41] && dv_side_ff[41].kind == dce_pkg::KIND_HYP && !dv_sat_ff[41])
         |-> (dv_q_ff[41] <= dce_pkg::E_CAP))
      else $error("divider quotient out of range");

   // a finished item held by a full buffer is not dropped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ex_v_ff[32] && !en) |=> ex_v_ff[32])
      else $error("stalled item lost");

endmodule

`default_nettype wire
